// ===== rtl/rbv_pkg.sv =====
package rbv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 32;
  localparam int RAD_W = 31;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int SQRT_STAGES = 31;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_FORCE    = 3'd4
  } reg_idx_e;

endpackage

// ===== rtl/radial_burst_velocity_top.sv =====
// FRAC_BITS sets the fixed-point format; the default gives Q16.16.
// Throughput: one request per cycle while no result is stalled; the square root takes one result
// bit per stage and the three divisions one quotient bit per stage, all fully pipelined.
// A stalled result holds the whole pipeline, so nothing is lost or repeated.
// Reset is asynchronous and active low; it clears the valid bits and the configuration registers.
module radial_burst_velocity_top import rbv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] query_x_i,
  input  logic signed [COORD_W-1:0] query_y_i,
  input  logic signed [COORD_W-1:0] query_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] vel_x_o,
  output logic signed [COORD_W-1:0] vel_y_o,
  output logic signed [COORD_W-1:0] vel_z_o,
  output logic                      inside_res_o
);

  localparam int QW = FRAC_BITS + 1;
  localparam int RW = RAD_W + FRAC_BITS + 1;
  localparam int DV_N = QW;

  typedef struct packed {
    logic             in_rad;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][30:0] mag;
    logic [61:0]      s;
    logic [62:0]      res;
  } sqs_t;

  typedef struct packed {
    logic               in_rad;
    logic               zero;
    logic [2:0]         neg;
    logic [30:0]        len;
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] q;
  } dvs_t;

  logic [31:0] cx_q, cy_q, cz_q, force_q;
  logic [30:0] rad_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      rad_q <= '0;
      force_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X: cx_q <= pwdata;
        REG_CENTER_Y: cy_q <= pwdata;
        REG_CENTER_Z: cz_q <= pwdata;
        REG_RADIUS:   rad_q <= pwdata[30:0];
        REG_FORCE:    force_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X: prdata = cx_q;
      REG_CENTER_Y: prdata = cy_q;
      REG_CENTER_Z: prdata = cz_q;
      REG_RADIUS:   prdata = {1'b0, rad_q};
      REG_FORCE:    prdata = force_q;
      default:      prdata = '0;
    endcase
  end

  logic adv;
  logic out_vld_q;
  assign adv = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  // Offsets and magnitudes.
  logic             a_vld_q;
  logic [2:0]       a_neg_q;
  logic [2:0][31:0] a_mag_q;
  logic [2:0][32:0] dif;
  logic [2:0][31:0] qin, cin;

  assign qin = {query_z_i, query_y_i, query_x_i};
  assign cin = {cz_q, cy_q, cx_q};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = {qin[i][31], qin[i]} - {cin[i][31], cin[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (adv) a_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_neg_q[i] <= dif[i][32];
        a_mag_q[i] <= dif[i][32] ? 32'(33'd0 - dif[i]) : dif[i][31:0];
      end
    end
  end

  // Squares.
  logic             b_vld_q;
  logic [2:0]       b_neg_q;
  logic [2:0][31:0] b_mag_q;
  logic [2:0][63:0] b_sq_q;
  logic [61:0]      b_rsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (adv) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_q[i] <= 64'(a_mag_q[i]) * 64'(a_mag_q[i]);
      end
      b_neg_q <= a_neg_q;
      b_mag_q <= a_mag_q;
      b_rsq_q <= 62'(rad_q) * 62'(rad_q);
    end
  end

  // Sum of squares and radius test.
  logic        c_vld_q;
  sqs_t        c_q;
  logic [65:0] sum;

  assign sum = 66'(b_sq_q[0]) + 66'(b_sq_q[1]) + 66'(b_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (adv) c_vld_q <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q.in_rad <= (sum <= 66'(b_rsq_q));
      c_q.zero <= (sum == 66'd0);
      c_q.neg <= b_neg_q;
      for (int i = 0; i < 3; i++) c_q.mag[i] <= b_mag_q[i][30:0];
      c_q.s <= sum[61:0];
      c_q.res <= '0;
    end
  end

  // Square root, one result bit per stage.
  logic [SQRT_STAGES-1:0] sq_vld_q;
  sqs_t                   sq_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [62:0] BITV = 63'(1) << (2 * (SQRT_STAGES - 1 - k));
    sqs_t        src, nxt;
    logic        src_vld;
    logic [62:0] t;

    if (k == 0) begin : g_first
      assign src = c_q;
      assign src_vld = c_vld_q;
    end else begin : g_rest
      assign src = sq_q[k-1];
      assign src_vld = sq_vld_q[k-1];
    end

    always_comb begin
      nxt = src;
      t = src.res + BITV;
      if ({1'b0, src.s} >= t) begin
        nxt.s = 62'({1'b0, src.s} - t);
        nxt.res = (src.res >> 1) + BITV;
      end else begin
        nxt.res = src.res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_vld_q[k] <= 1'b0;
      else if (adv) sq_vld_q[k] <= src_vld;
    end

    always_ff @(posedge clk_i) begin
      if (adv) sq_q[k] <= nxt;
    end
  end

  // Division of each magnitude by the length, one quotient bit per stage.
  dvs_t            dv_in;
  logic [DV_N-1:0] dv_vld_q;
  dvs_t            dv_q [DV_N];

  always_comb begin
    dv_in.in_rad = sq_q[SQRT_STAGES-1].in_rad;
    dv_in.zero = sq_q[SQRT_STAGES-1].zero;
    dv_in.neg = sq_q[SQRT_STAGES-1].neg;
    dv_in.len = sq_q[SQRT_STAGES-1].res[30:0];
    for (int i = 0; i < 3; i++) begin
      dv_in.rem[i] = RW'(sq_q[SQRT_STAGES-1].mag[i]) << FRAC_BITS;
      dv_in.q[i] = '0;
    end
  end

  for (genvar k = 0; k < DV_N; k++) begin : g_div
    localparam int SH = FRAC_BITS - k;
    dvs_t          src, nxt;
    logic          src_vld;
    logic [RW-1:0] dv;

    if (k == 0) begin : g_first
      assign src = dv_in;
      assign src_vld = sq_vld_q[SQRT_STAGES-1];
    end else begin : g_rest
      assign src = dv_q[k-1];
      assign src_vld = dv_vld_q[k-1];
    end

    assign dv = RW'(src.len) << SH;

    always_comb begin
      nxt = src;
      for (int i = 0; i < 3; i++) begin
        if (src.rem[i] >= dv) begin
          nxt.rem[i] = src.rem[i] - dv;
          nxt.q[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[k] <= 1'b0;
      else if (adv) dv_vld_q[k] <= src_vld;
    end

    always_ff @(posedge clk_i) begin
      if (adv) dv_q[k] <= nxt;
    end
  end

  // Scaling by the force.
  logic             m_vld_q;
  logic             m_in_rad_q;
  logic [2:0]       m_neg_q;
  logic [2:0][32:0] m_mag_q;
  logic             fneg;
  logic [31:0]      fm;
  logic [2:0][QW-1:0] u;
  logic [2:0]       uneg;

  assign fneg = force_q[31];
  assign fm = fneg ? 32'(33'd0 - {1'b0, force_q}) : force_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_q[DV_N-1].zero) begin
        u[i] = (i == 0) ? (QW'(1) << FRAC_BITS) : '0;
        uneg[i] = 1'b0;
      end else begin
        u[i] = dv_q[DV_N-1].q[i];
        uneg[i] = dv_q[DV_N-1].neg[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (adv) m_vld_q <= dv_vld_q[DV_N-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_in_rad_q <= dv_q[DV_N-1].in_rad;
      for (int i = 0; i < 3; i++) begin
        m_mag_q[i] <= 33'(((32 + QW)'(fm) * (32 + QW)'(u[i])) >> FRAC_BITS);
        m_neg_q[i] <= fneg ^ uneg[i];
      end
    end
  end

  // Saturation and output register.
  logic [2:0][31:0] sat;
  logic [2:0][31:0] vel_q;
  logic             in_rad_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!m_in_rad_q || m_mag_q[i] == 33'd0) begin
        sat[i] = '0;
      end else if (m_neg_q[i]) begin
        sat[i] = (m_mag_q[i] > 33'h080000000) ? 32'h80000000
                                              : 32'(33'd0 - m_mag_q[i]);
      end else begin
        sat[i] = (m_mag_q[i] > 33'h07FFFFFFF) ? 32'h7FFFFFFF : m_mag_q[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= m_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vel_q <= sat;
      in_rad_q <= m_in_rad_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign vel_x_o = vel_q[0];
  assign vel_y_o = vel_q[1];
  assign vel_z_o = vel_q[2];
  assign inside_res_o = in_rad_q;

endmodule

// ===== rtl/rbv_chk.sv =====
module rbv_chk import rbv_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [COORD_W-1:0] vel_x_o,
  input logic [COORD_W-1:0] vel_y_o,
  input logic [COORD_W-1:0] vel_z_o,
  input logic               inside_res_o
);

  // A point outside the radius never carries a velocity.
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !inside_res_o) |->
      (vel_x_o == '0 && vel_y_o == '0 && vel_z_o == '0))
    else $error("outside point with non-zero velocity");

  // The input side is held only by a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // A waiting result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(vel_x_o) && $stable(vel_y_o) && $stable(vel_z_o)
       && $stable(inside_res_o)))
    else $error("stalled result changed");

endmodule

bind radial_burst_velocity_top rbv_chk u_rbv_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .vel_x_o      (vel_x_o),
  .vel_y_o      (vel_y_o),
  .vel_z_o      (vel_z_o),
  .inside_res_o (inside_res_o)
);

// ===== tb/radial_burst_velocity_top_test.sv =====
module radial_burst_velocity_top_test;
  import rbv_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 37 + FB;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 1750;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               in_rad;
  } velocity_t;

  class burst_scoreboard;
    logic signed [31:0] cx, cy, cz, force_q;
    logic [30:0]        radius;
    velocity_t          pending[$];
    int                 errors;

    function new();
      cx = 0; cy = 0; cz = 0; force_q = 0; radius = 0; errors = 0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] s);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s = s - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic signed [31:0] scale(logic uneg, logic [63:0] umag);
      logic [63:0] fm;
      logic [63:0] m;
      logic        neg;
      fm = force_q < 0 ? 64'(-65'(force_q)) : 64'(force_q);
      m = (fm * umag) >> FB;
      neg = (force_q < 0) != uneg;
      if (m == 0) return 0;
      if (neg) begin
        if (m > 64'h8000_0000) m = 64'h8000_0000;
        return 32'(-m);
      end
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      return 32'(m);
    endfunction

    function void note_query(logic signed [31:0] qx, logic signed [31:0] qy,
                             logic signed [31:0] qz);
      logic signed [33:0] d[3];
      logic [33:0]        m[3];
      logic [67:0]        sum;
      logic [63:0]        len;
      logic [63:0]        u;
      velocity_t          v;
      d[0] = 34'(qx) - 34'(cx);
      d[1] = 34'(qy) - 34'(cy);
      d[2] = 34'(qz) - 34'(cz);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = d[i] < 0 ? -d[i] : d[i];
        sum += 68'(m[i]) * 68'(m[i]);
      end
      v = '0;
      if (sum <= 68'(radius) * 68'(radius)) begin
        v.in_rad = 1'b1;
        if (sum == 0) begin
          v.vx = scale(1'b0, 64'd1 << FB);
        end else begin
          len = isqrt(64'(sum));
          u = (64'(m[0]) << FB) / len; v.vx = scale(d[0] < 0, u);
          u = (64'(m[1]) << FB) / len; v.vy = scale(d[1] < 0, u);
          u = (64'(m[2]) << FB) / len; v.vz = scale(d[2] < 0, u);
        end
      end
      pending.push_back(v);
    endfunction

    function void check_velocity(velocity_t got);
      velocity_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.vx !== e.vx) begin $error("vel_x exp %h got %h", e.vx, got.vx); errors++; end
      if (got.vy !== e.vy) begin $error("vel_y exp %h got %h", e.vy, got.vy); errors++; end
      if (got.vz !== e.vz) begin $error("vel_z exp %h got %h", e.vz, got.vz); errors++; end
      if (got.in_rad !== e.in_rad) begin
        $error("inside_res exp %b got %b", e.in_rad, got.in_rad); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [DATA_W-1:0] pwdata = 0, prdata;
  logic pready;
  logic in_valid_i = 0, in_stall_o;
  logic signed [31:0] query_x_i = 0, query_y_i = 0, query_z_i = 0;
  logic out_valid_o, out_stall_i = 0;
  logic signed [31:0] vel_x_o, vel_y_o, vel_z_o;
  logic inside_res_o;
  int idle_cycles = 0;
  int stall_mode = 0;
  burst_scoreboard sb = new();

  radial_burst_velocity_top dut (.*);

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_query(query_x_i, query_y_i, query_z_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_velocity({vel_x_o, vel_y_o, vel_z_o, inside_res_o});
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** radial_burst_velocity_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(4 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_CENTER_X: sb.cx = val;
      REG_CENTER_Y: sb.cy = val;
      REG_CENTER_Z: sb.cz = val;
      REG_RADIUS:   sb.radius = val[30:0];
      REG_FORCE:    sb.force_q = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic setup(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                       logic [31:0] r, logic [31:0] f);
    drain();
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CENTER_Z, z);
    write_reg(REG_RADIUS, r);
    write_reg(REG_FORCE, f);
  endtask

  task automatic send_query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_valid_i <= 1; query_x_i <= x; query_y_i <= y; query_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [31:0] near(logic [31:0] c, int spread);
    return c + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic random_burst(int n, int spread);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        if ($urandom_range(0, 9) == 0) send_query($urandom, $urandom, $urandom);
        else send_query(near(sb.cx, spread), near(sb.cy, spread), near(sb.cz, spread));
      end
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    in_valid_i <= 0;
  endtask

  initial begin
    logic [31:0] r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_query(0, 0, 0);
    send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    in_valid_i <= 0;
    setup(32'h0001_0000, 32'hFFFF_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h0001_0000, 32'hFFFF_0000, 0);
    send_query(32'h0002_0000, 32'hFFFF_0000, 0);
    send_query(0, 32'hFFFF_0000, 0);
    send_query(32'h0001_0000, 32'h7FFF_FFFF, 0);
    send_query(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000);
    send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    in_valid_i <= 0;
    setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8010_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8010_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h8003_0000, 32'h7FFB_FFFF, 32'h8004_0000);
    in_valid_i <= 0;
    setup(0, 0, 0, 0, 32'h0003_0000);
    send_query(0, 0, 0);
    send_query(1, 0, 0);
    in_valid_i <= 0;
    for (int ph = 0; ph < 10; ph++) begin
      r = (ph % 3 == 0) ? $urandom_range(0, 32'h0100_0000) : $urandom & 32'h7FFF_FFFF;
      if (ph == 9) r = 32'h7FFF_FFFF;
      setup($urandom, $urandom, $urandom, r,
            (ph == 4) ? 32'h8000_0000 : (ph == 5) ? 32'h7FFF_FFFF : $urandom);
      random_burst(N_RANDOM / 10, (r > 32'h3FFF_FFFF) ? 32'h3FFF_FFFF : r + r / 4 + 2);
    end
    drain();
    if (sb.errors == 0) $display("** radial_burst_velocity_top: PASSED **");
    else $display("** radial_burst_velocity_top: FAILED **");
    $finish;
  end
endmodule

// ===== radial_burst_velocity_top.f =====
rtl/rbv_pkg.sv
rtl/radial_burst_velocity_top.sv
rtl/rbv_chk.sv
tb/radial_burst_velocity_top_test.sv
